/* rtl/dzbe_pkg.sv */
// Shared types and constants of the delta / zigzag byte encoder.
`default_nettype none

package dzbe_pkg;

    localparam int unsigned JOB_BYTES = 6;
    localparam int unsigned JOB_CNT_W = 3;
    localparam int unsigned LEN_W     = 31;
    localparam int unsigned MODE_W    = 2;

    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

    localparam logic [MODE_W-1:0] MODE_RAW    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ZIGZAG = 2'd1;
    localparam logic [MODE_W-1:0] MODE_XOR    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam logic CFG_CODING_MODE  = 1'b0;
    localparam logic CFG_FRAME_LENGTH = 1'b1;

    localparam logic [JOB_CNT_W-1:0] CNT_SINGLE = 3'd1;
    localparam logic [JOB_CNT_W-1:0] CNT_ESCAPE = 3'd3;
    localparam logic [JOB_CNT_W-1:0] CNT_HEADER = 3'd6;

    // One input item's worth of output bytes, first byte in slot 0.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [JOB_CNT_W-1:0]      count;
        logic                      frame_done;
    } job_t;

endpackage

`default_nettype wire

/* rtl/dzbe_front.sv */
// Front part: configuration registers, frame tracking and coding of each item.
`default_nettype none

module dzbe_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_index,
    input  wire logic [dzbe_pkg::LEN_W-1:0]        cfg_data,
    input  wire logic                              push,
    input  wire logic [7:0]                        data_byte,
    output      dzbe_pkg::job_t                    job
);

    logic [dzbe_pkg::MODE_W-1:0] mode_reg;
    logic [dzbe_pkg::LEN_W-1:0]  length_reg;
    logic [7:0]                  prev_reg;
    logic [dzbe_pkg::LEN_W-1:0]  left_reg;
    logic [dzbe_pkg::LEN_W-1:0]  left_next;

    logic       first;
    logic [7:0] zz_first;
    logic       ge;
    logic [7:0] mag;
    logic [8:0] zz;

    assign first    = (left_reg == '0);
    assign zz_first = {data_byte[6:0], 1'b0} ^ {8{data_byte[7]}};
    assign ge       = (data_byte >= prev_reg);
    assign mag      = ge ? (data_byte - prev_reg) : (prev_reg - data_byte);
    assign zz       = ge ? {mag, 1'b0} : ({mag, 1'b0} - 9'd1);

    always_comb
    begin
        job = '0;
        if (first)
        begin
            left_next    = (length_reg == '0) ? '0 : (length_reg - 1'b1);
            job.count    = dzbe_pkg::CNT_HEADER;
            job.bytes[0] = {1'b0, length_reg[30:24]};
            job.bytes[1] = length_reg[23:16];
            job.bytes[2] = length_reg[15:8];
            job.bytes[3] = length_reg[7:0];
            job.bytes[4] = {6'b0, mode_reg};
            job.bytes[5] = (mode_reg == dzbe_pkg::MODE_ZIGZAG) ? zz_first : data_byte;
        end
        else
        begin
            left_next = left_reg - 1'b1;
            job.count = dzbe_pkg::CNT_SINGLE;
            case (mode_reg)
                dzbe_pkg::MODE_ZIGZAG:
                begin
                    if (zz >= 9'd255)
                    begin
                        job.count    = dzbe_pkg::CNT_ESCAPE;
                        job.bytes[0] = dzbe_pkg::ESCAPE_BYTE;
                        job.bytes[1] = zz[7:0];
                        job.bytes[2] = {7'b0, zz[8]};
                    end
                    else
                    begin
                        job.bytes[0] = zz[7:0];
                    end
                end
                dzbe_pkg::MODE_XOR:
                begin
                    job.bytes[0] = data_byte ^ prev_reg;
                end
                default:
                begin
                    // Raw mode and the unused mode code send raw differences.
                    job.bytes[0] = data_byte - prev_reg;
                end
            endcase
        end
        job.frame_done = (left_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= dzbe_pkg::MODE_RAW;
            length_reg <= dzbe_pkg::LEN_W'(1);
            prev_reg   <= '0;
            left_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    dzbe_pkg::CFG_CODING_MODE:  mode_reg   <= cfg_data[dzbe_pkg::MODE_W-1:0];
                    dzbe_pkg::CFG_FRAME_LENGTH: length_reg <= cfg_data;
                endcase
            end
            if (push)
            begin
                prev_reg <= data_byte;
                left_reg <= left_next;
            end
        end
    end

    // A header is produced exactly when a frame starts.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((job.count == dzbe_pkg::CNT_HEADER) == first))
        else $error("header not aligned with frame start");

endmodule

`default_nettype wire

/* rtl/dzbe_fifo.sv */
// Short queue of coded jobs between the front and the back part.
`default_nettype none

module dzbe_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dzbe_pkg::job_t push_job,
    output      logic           full,
    input  wire logic           pop,
    output      logic           head_valid,
    output      dzbe_pkg::job_t head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dzbe_pkg::job_t   store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_job   = store_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : (wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : (rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue popped while empty");

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");

endmodule

`default_nettype wire

/* rtl/dzbe_back.sv */
// Back part: sends the bytes of each queued job, one per cycle unless the output stalls, through the output register.
`default_nettype none

module dzbe_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire dzbe_pkg::job_t head_job,
    output      logic           pop,
    output      logic           out_valid,
    input  wire logic           out_stall,
    output      logic [7:0]     out_byte,
    output      logic           last_of_run,
    output      logic           frame_done
);

    dzbe_pkg::job_t                  job_reg;
    logic                            active_reg;
    logic [dzbe_pkg::JOB_CNT_W-1:0]  idx_reg;
    logic                            out_valid_reg;
    logic [7:0]                      out_byte_reg;
    logic                            last_reg;
    logic                            done_reg;

    logic       src_valid;
    logic [7:0] src_byte;
    logic       src_last;
    logic       src_done;
    logic       load;

    // A job in progress has priority; otherwise the queue head starts at once.
    assign src_valid = active_reg || head_valid;
    assign src_byte  = active_reg ? job_reg.bytes[idx_reg] : head_job.bytes[0];
    assign src_last  = active_reg ? (idx_reg == (job_reg.count - 1'b1))
                                  : (head_job.count == dzbe_pkg::CNT_SINGLE);
    assign src_done  = src_last && (active_reg ? job_reg.frame_done : head_job.frame_done);
    assign load      = src_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && !active_reg;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign frame_done  = done_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= src_byte;
            last_reg     <= src_last;
            done_reg     <= src_done;
            if (pop)
            begin
                job_reg <= head_job;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (active_reg)
                begin
                    if (src_last)
                    begin
                        active_reg <= 1'b0;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                else if (!src_last)
                begin
                    active_reg <= 1'b1;
                    idx_reg    <= dzbe_pkg::JOB_CNT_W'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg != '0) && (idx_reg < job_reg.count))
        else $error("byte index outside the current job");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("frame end on a byte that does not close its item");

endmodule

`default_nettype wire

/* rtl/delta_zigzag_byte_encoder_top.sv */
// An accepted item is queued as a job; its bytes then leave through the output register.
// Throughput: the output sends one byte a cycle unless stalled; an item gives one byte,
// three on a zigzag escape, six at a frame start, so the output sets the sustained item rate.
// Items are taken one a cycle while the job queue between the front and back parts has room.
// Reset clears the queue, the output register and the frame state, and sets coding mode 0
// and frame length 1.
`default_nettype none

module delta_zigzag_byte_encoder_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_index,
    input  wire logic [dzbe_pkg::LEN_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic [7:0]                 data_byte,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      logic [7:0]                 out_byte,
    output      logic                       last_of_run,
    output      logic                       frame_done
);

    dzbe_pkg::job_t new_job;
    dzbe_pkg::job_t head_job;
    logic           full;
    logic           push;
    logic           pop;
    logic           head_valid;

    assign in_stall = full;
    assign push     = in_valid && !full;

    dzbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .data_byte (data_byte),
        .job       (new_job)
    );

    dzbe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (new_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    dzbe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_job    (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .frame_done  (frame_done)
    );

endmodule

`default_nettype wire
